/* rtl/core/fff_pkg.sv */
// Shared widths and constants for the fire frame filter.
package fff_pkg;

	localparam int FRAME_WIDTH_DEF = 64;
	localparam int HEAT_W = 8;
	localparam int COOL_W = 6;
	localparam int SUM_W = 12;
	localparam int MUL_W = 5;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam int SCALE_SHIFT = 8;
	localparam logic [MUL_W-1:0] COOL_MUL = 5'd28;
	localparam logic [HEAT_W-1:0] HEAT_MAX_OUT = 8'd251;

endpackage

/* rtl/core/fire_frame_filter_core.sv */
// Fire frame filter: 3x3 cooling filter over a raster pixel stream.
// A result is registered as the item completing its window leaves the middle stage.
// Throughput: one item per cycle while pix_stall is low; the line stores are read and written once per item.
// An item is taken while a finished result waits, as long as the middle stage is free.
// Reset clears position counters and valid flags; line stores and window keep old contents.
// After reset the first frame starts at row 0, column 0 even without frame_start.
module fire_frame_filter_core
	import fff_pkg::*;
#(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  logic [HEAT_W-1:0] heat_in,
	input  logic [COOL_W-1:0] cooling,
	input  logic              frame_start,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [HEAT_W-1:0] heat_out,
	output logic              frame_done
);

	localparam int CW = $clog2(FRAME_WIDTH);
	localparam logic [CW-1:0] LAST_POS = CW'(FRAME_WIDTH - 1);
	localparam logic [CW-1:0] FIRST_OUT = CW'(2);

	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] col_cur, row_cur;
	logic accept;
	logic s1_move, s2_free;

	logic [HEAT_W-1:0] upper_mem [FRAME_WIDTH];
	logic [HEAT_W-1:0] lower_mem [FRAME_WIDTH];

	logic              valid_s1;
	logic              prod_s1;
	logic              done_s1;
	logic [CW-1:0]     addr_s1;
	logic [HEAT_W-1:0] heat_s1;
	logic [COOL_W-1:0] cool_s1;
	logic [HEAT_W-1:0] upper_rd_s1;
	logic [HEAT_W-1:0] mid_s1;
	logic [HEAT_W-1:0] fwd_data_s1;
	logic              fwd_s1;
	logic [HEAT_W-1:0] top_s1;

	logic [HEAT_W-1:0] win_q [6];

	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  cooled;
	logic [PROD_W-1:0] scaled;

	logic              res_valid_q;
	logic [HEAT_W-1:0] heat_out_q;
	logic              frame_done_q;

	assign s2_free = !res_valid_q || !res_stall;
	assign s1_move = valid_s1 && (!prod_s1 || s2_free);
	assign pix_stall = valid_s1 && !s1_move;
	assign accept = pix_valid && !pix_stall;

	assign col_cur = frame_start ? '0 : col_q;
	assign row_cur = frame_start ? '0 : row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_cur == LAST_POS) begin
				col_q <= '0;
				row_q <= (row_cur == LAST_POS) ? '0 : row_cur + 1'b1;
			end else begin
				col_q <= col_cur + 1'b1;
				row_q <= row_cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_s1 <= lower_mem[col_cur];
			lower_mem[col_cur] <= heat_in;
			upper_rd_s1 <= upper_mem[col_cur];
		end
		if (s1_move) begin
			upper_mem[addr_s1] <= mid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_cur;
			heat_s1 <= heat_in;
			cool_s1 <= cooling;
			prod_s1 <= (row_cur >= FIRST_OUT) && (col_cur >= FIRST_OUT);
			done_s1 <= (row_cur == LAST_POS) && (col_cur == LAST_POS);
			fwd_s1 <= s1_move && (addr_s1 == col_cur);
			fwd_data_s1 <= mid_s1;
		end
	end

	assign top_s1 = fwd_s1 ? fwd_data_s1 : upper_rd_s1;

	always_ff @(posedge clk) begin
		if (s1_move) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= heat_s1;
		end
	end

	always_comb begin
		sum = SUM_W'(top_s1) + SUM_W'(mid_s1) + SUM_W'(heat_s1)
			+ SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
			+ SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5]);
		cooled = (SUM_W'(cool_s1) > sum) ? '0 : sum - SUM_W'(cool_s1);
		scaled = PROD_W'(cooled) * PROD_W'(COOL_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_free) begin
			res_valid_q <= s1_move && prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_move && prod_s1) begin
			heat_out_q <= scaled[SCALE_SHIFT +: HEAT_W];
			frame_done_q <= done_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign heat_out = heat_out_q;
	assign frame_done = frame_done_q;

endmodule

/* rtl/core/fff_checker.sv */
// Port-level checks for the fire frame filter and their binding to the top level.
module fff_checker
	import fff_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input logic              res_valid,
	input logic              res_stall,
	input logic [HEAT_W-1:0] heat_out,
	input logic              frame_done
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(heat_out) && $stable(frame_done))
		else $error("Stalled result item changed.");

	a_heat_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> heat_out <= HEAT_MAX_OUT)
		else $error("Result heat is above the largest reachable value.");

	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid || !res_stall) |-> !pix_stall)
		else $error("Input stalled while the result side was free.");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && !pix_stall, 2))
		else $error("Result item appeared without an item accepted two cycles before.");

endmodule

bind fire_frame_filter_core fff_checker u_fff_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_stall  (pix_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.heat_out   (heat_out),
	.frame_done (frame_done)
);

/* test/testbench.sv */
// Self-checking testbench for the fire frame filter core.
`timescale 1ns / 100ps

module testbench;
	import fff_pkg::*;

	localparam int FW = FRAME_WIDTH_DEF;
	localparam int RUN_LIMIT = 100000;

	typedef struct {
		logic [HEAT_W-1:0] heat;
		logic [COOL_W-1:0] cool;
		logic start;
		int unsigned gap;
		bit drain;
	} pixel_item_t;

	typedef struct {
		logic [HEAT_W-1:0] heat;
		logic done;
	} heat_result_t;

	typedef enum {HEAT_HOT, HEAT_COLD, HEAT_SPIKY, HEAT_RANDOM} heat_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	logic [HEAT_W-1:0] heat_in = '0;
	logic [COOL_W-1:0] cooling = '0;
	logic frame_start = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [HEAT_W-1:0] heat_out;
	logic frame_done;

	pixel_item_t pending_pixels[$];
	heat_result_t awaited_results[$];

	logic [HEAT_W-1:0] line_rows[2*FW];
	logic [HEAT_W-1:0] window_cols[6];
	int unsigned pos_col = 0;
	int unsigned pos_row = 0;

	pixel_item_t next_pix;
	bit have_next = 1'b0;
	int unsigned gap_left = 0;
	bit send_calm = 1'b0;

	int unsigned stall_left = 0;
	bit recv_calm = 1'b0;
	int unsigned results_seen = 0;
	int unsigned error_count = 0;

	fire_frame_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.heat_in(heat_in),
		.cooling(cooling),
		.frame_start(frame_start),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.heat_out(heat_out),
		.frame_done(frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic predict_heat(input logic [HEAT_W-1:0] heat, input logic [COOL_W-1:0] cool,
			input logic start);
		int unsigned c;
		int unsigned r;
		int unsigned acc;
		logic [HEAT_W-1:0] upper;
		logic [HEAT_W-1:0] middle;
		heat_result_t res;
		if (start) begin
			pos_col = 0;
			pos_row = 0;
		end
		c = pos_col;
		r = pos_row;
		upper = line_rows[c];
		middle = line_rows[FW + c];
		line_rows[c] = middle;
		line_rows[FW + c] = heat;
		if (r >= 2 && c >= 2) begin
			acc = upper + middle + heat;
			for (int i = 0; i < 6; i++)
				acc += window_cols[i];
			acc = (cool > acc) ? 0 : acc - cool;
			acc = (acc * COOL_MUL) >> SCALE_SHIFT;
			res.heat = acc[HEAT_W-1:0];
			res.done = (r == FW - 1) && (c == FW - 1);
			awaited_results.insert(awaited_results.size(), res);
		end
		window_cols[0] = window_cols[3];
		window_cols[1] = window_cols[4];
		window_cols[2] = window_cols[5];
		window_cols[3] = upper;
		window_cols[4] = middle;
		window_cols[5] = heat;
		c++;
		if (c >= FW) begin
			c = 0;
			r++;
			if (r >= FW)
				r = 0;
		end
		pos_col = c;
		pos_row = r;
	endtask

	task automatic add_pixel(input logic [HEAT_W-1:0] heat, input logic [COOL_W-1:0] cool,
			input logic start, input bit drain);
		pixel_item_t item;
		item.heat = heat;
		item.cool = cool;
		item.start = start;
		item.gap = send_calm ? 0 : $urandom_range(0, 8);
		item.drain = drain;
		pending_pixels.insert(pending_pixels.size(), item);
	endtask

	function automatic logic [HEAT_W-1:0] draw_heat(heat_mode_t mode);
		case (mode)
			HEAT_HOT: return 8'hFF;
			HEAT_COLD: return 8'h00;
			HEAT_SPIKY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return HEAT_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [COOL_W-1:0] draw_cooling();
		case ($urandom_range(0, 7))
			0: return 6'h00;
			1: return 6'h3F;
			default: return COOL_W'($urandom_range(0, 63));
		endcase
	endfunction

	// Rows come in bands of four with a shared heat pattern, so that whole
	// windows of saturated or empty pixels occur.
	task automatic add_frame(input logic start, input int unsigned count, input bit drain);
		heat_mode_t mode;
		mode = HEAT_RANDOM;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % FW == 0) begin
				send_calm = ($urandom_range(0, 3) == 0);
				if ((i / FW) % 4 == 0) begin
					case ($urandom_range(0, 7))
						0: mode = HEAT_HOT;
						1: mode = HEAT_COLD;
						2: mode = HEAT_SPIKY;
						default: mode = HEAT_RANDOM;
					endcase
				end
			end
			add_pixel(draw_heat(mode), draw_cooling(), (i == 0) && start, (i == 0) && drain);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			heat_in <= '0;
			cooling <= '0;
			frame_start <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall)
				predict_heat(heat_in, cooling, frame_start);
			if (!pix_valid || !pix_stall) begin
				if (!have_next && pending_pixels.size() != 0) begin
					next_pix = pending_pixels.pop_front();
					gap_left = next_pix.gap;
					have_next = 1'b1;
				end
				if (have_next && gap_left == 0 &&
						!(next_pix.drain && awaited_results.size() != 0)) begin
					pix_valid <= 1'b1;
					heat_in <= next_pix.heat;
					cooling <= next_pix.cool;
					frame_start <= next_pix.start;
					have_next = 1'b0;
				end else begin
					pix_valid <= 1'b0;
					if (have_next && gap_left != 0)
						gap_left--;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result: heat_out=%0d frame_done=%b",
							heat_out, frame_done);
				end else begin
					heat_result_t want;
					want = awaited_results.pop_front();
					if (heat_out !== want.heat || frame_done !== want.done) begin
						error_count++;
						if (error_count <= 10)
							$display("result %0d: heat_out %0d/%0d, frame_done %b/%b",
								results_seen, heat_out, want.heat,
								frame_done, want.done);
					end
				end
				results_seen++;
				if (results_seen % 50 == 0)
					recv_calm = ($urandom_range(0, 2) == 0);
				stall_left = recv_calm ? 0 : $urandom_range(0, 8);
			end
			res_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [HEAT_W-1:0] h;
		logic [COOL_W-1:0] k;
		for (int i = 0; i < 2 * FW; i++)
			line_rows[i] = '0;
		for (int i = 0; i < 6; i++)
			window_cols[i] = '0;

		// The first item after reset carries no frame marker; restarts follow
		// in the middle of the first row and back to back.
		for (int i = 0; i < 24; i++) begin
			case (i % 4)
				0: h = 8'hFF;
				1: h = 8'h00;
				2: h = 8'h55;
				default: h = 8'hAA;
			endcase
			k = (i % 3 == 0) ? 6'h3F : (i % 3 == 1) ? 6'h00 : 6'h2A;
			send_calm = (i >= 16);
			add_pixel(h, k, (i == 5) || (i == 12) || (i == 13), 1'b0);
		end

		add_frame(1'b1, 4 * FW, 1'b1);
		// A frame abandoned partway by a new frame marker.
		add_frame(1'b1, $urandom_range(3 * FW / 2, 5 * FW / 2), 1'b0);
		send_calm = 1'b0;
		for (int i = 0; i < 100; i++)
			add_pixel(HEAT_W'($urandom_range(0, 255)), COOL_W'($urandom_range(0, 63)),
				$urandom_range(0, 9) == 0, 1'b0);
		add_frame(1'b1, 3 * FW, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_pixels.size() != 0 || have_next || pix_valid ||
				awaited_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
